FILE: rtl/kscan_pkg.sv
// Package for the keypad scanner with number entry.
// Holds the scan phase type, key codes, the key table and the event structs.
// No dependencies.
`default_nettype none

package kscan_pkg;

  // Largest number of digits an entry can hold.
  localparam logic [3:0] MAX_DIGITS = 4'd9;

  localparam int VALUE_W = 30;
  localparam int DIGITS_W = 4;

  // Key codes that the entry logic reacts to.
  localparam logic [6:0] KEY_ZERO  = 7'h30;
  localparam logic [6:0] KEY_NINE  = 7'h39;
  localparam logic [6:0] KEY_EQUAL = 7'h3D;
  localparam logic [6:0] KEY_STAR  = 7'h2A;

  localparam logic [3:0] COLS_IDLE = 4'hF;

  typedef enum logic [2:0] {
    PH_SETTLE      = 3'd0,
    PH_DEB_PRESS   = 3'd1,
    PH_RELEASE     = 3'd2,
    PH_DEB_RELEASE = 3'd3
  } scan_phase_t;

  // A completed key press, as seen by the entry logic.
  typedef struct packed {
    logic       valid;
    logic [6:0] code;
  } key_evt_t;

  // What the entry logic reports for one tick.
  typedef struct packed {
    logic                number_valid;
    logic [VALUE_W-1:0]  number_value;
    logic [DIGITS_W-1:0] digit_count;
    logic                digit_dropped;
  } entry_res_t;

  // Key layout: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 = D.
  function automatic logic [6:0] key_code_of(input logic [1:0] row, input logic [1:0] col);
    logic [6:0] code;
    case ({row, col})
      4'h0:    code = 7'h31;
      4'h1:    code = 7'h32;
      4'h2:    code = 7'h33;
      4'h3:    code = 7'h41;
      4'h4:    code = 7'h34;
      4'h5:    code = 7'h35;
      4'h6:    code = 7'h36;
      4'h7:    code = 7'h42;
      4'h8:    code = 7'h37;
      4'h9:    code = 7'h38;
      4'hA:    code = 7'h39;
      4'hB:    code = 7'h43;
      4'hC:    code = KEY_STAR;
      4'hD:    code = KEY_ZERO;
      4'hE:    code = KEY_EQUAL;
      default: code = 7'h44;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/kscan_if.sv
// Channel interfaces of the keypad scanner: tick input, result output and
// configuration write. Depends on kscan_pkg for field widths.
`default_nettype none

interface kscan_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] column_levels;

  modport source (output valid, output column_levels, input ready);
  modport sink   (input valid, input column_levels, output ready);
endinterface

interface kscan_out_if;
  logic                                valid;
  logic                                ready;
  logic [3:0]                          row_drive;
  logic                                key_valid;
  logic [6:0]                          key_char;
  logic                                number_valid;
  logic [kscan_pkg::VALUE_W-1:0]       number_value;
  logic [kscan_pkg::DIGITS_W-1:0]      digit_count;
  logic                                digit_dropped;

  modport source (output valid, output row_drive, output key_valid, output key_char,
                  output number_valid, output number_value, output digit_count,
                  output digit_dropped, input ready);
  modport sink   (input valid, input row_drive, input key_valid, input key_char,
                  input number_valid, input number_value, input digit_count,
                  input digit_dropped, output ready);
endinterface

interface kscan_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/kscan_scan.sv
// Row scan and debounce sequencer of the keypad scanner.
// Depends on kscan_pkg for the phase type, key table and event struct.
`default_nettype none

module kscan_scan (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                advance,
  input  wire logic [3:0]          column_levels,
  input  wire logic [7:0]          settle_ticks,
  input  wire logic [7:0]          debounce_ticks,
  output logic      [3:0]          row_drive,
  output kscan_pkg::key_evt_t      key_evt
);
  import kscan_pkg::*;

  scan_phase_t phase_r, phase_nxt;
  logic [1:0]  row_r, row_nxt;
  logic [1:0]  col_r, col_nxt;
  logic [7:0]  tick_r, tick_nxt;

  logic [7:0]  wait_limit;
  logic        wait_over;
  logic [1:0]  first_low;

  // Debounce phases count against the debounce time, everything else
  // against the settle time.
  assign wait_limit = (phase_r == PH_DEB_PRESS || phase_r == PH_DEB_RELEASE) ?
                      debounce_ticks : settle_ticks;
  assign wait_over  = (tick_r >= wait_limit);

  always_comb begin
    if (!column_levels[0]) begin
      first_low = 2'd0;
    end else if (!column_levels[1]) begin
      first_low = 2'd1;
    end else if (!column_levels[2]) begin
      first_low = 2'd2;
    end else begin
      first_low = 2'd3;
    end
  end

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    tick_nxt  = tick_r;
    case (phase_r)
      PH_DEB_PRESS: begin
        if (wait_over) begin
          phase_nxt = PH_RELEASE;
          tick_nxt  = 8'd0;
        end else begin
          tick_nxt = tick_r + 8'd1;
        end
      end
      PH_RELEASE: begin
        if (column_levels[col_r]) begin
          phase_nxt = PH_DEB_RELEASE;
          tick_nxt  = 8'd0;
        end
      end
      PH_DEB_RELEASE: begin
        if (wait_over) begin
          phase_nxt = PH_SETTLE;
          row_nxt   = 2'd0;
          tick_nxt  = 8'd0;
        end else begin
          tick_nxt = tick_r + 8'd1;
        end
      end
      default: begin
        // Settle, and any code outside the enum, which behaves the same.
        phase_nxt = PH_SETTLE;
        if (wait_over) begin
          tick_nxt = 8'd0;
          if (column_levels != COLS_IDLE) begin
            col_nxt   = first_low;
            phase_nxt = PH_DEB_PRESS;
          end else begin
            row_nxt = row_r + 2'd1;
          end
        end else begin
          tick_nxt = tick_r + 8'd1;
        end
      end
    endcase
  end

  // Outputs.
  always_comb begin
    row_drive     = ~(4'b0001 << row_r);
    key_evt.valid = (phase_r == PH_DEB_RELEASE) && wait_over;
    key_evt.code  = key_code_of(row_r, col_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SETTLE;
      row_r   <= 2'd0;
      col_r   <= 2'd0;
      tick_r  <= 8'd0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      tick_r  <= tick_nxt;
    end
  end

  // A completed key always returns the scan to row 0 in the settle phase.
  a_key_restarts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    advance && key_evt.valid |=> phase_r == PH_SETTLE && row_r == 2'd0 && tick_r == 8'd0)
    else $error("scan did not restart after a key");

  // The release wait moves on only once the hit column reads high.
  a_release_needs_high: assert property (@(posedge clk) disable iff (!rst_n)
    advance && phase_r == PH_RELEASE && !column_levels[col_r] |=> phase_r == PH_RELEASE)
    else $error("release wait left while column still low");

endmodule

`default_nettype wire

FILE: rtl/kscan_entry.sv
// Decimal number entry of the keypad scanner: append, delete and finish.
// Depends on kscan_pkg for key codes, widths and the event structs.
`default_nettype none

module kscan_entry (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 advance,
  input  wire kscan_pkg::key_evt_t  key_evt,
  output kscan_pkg::entry_res_t     entry_res
);
  import kscan_pkg::*;

  logic [VALUE_W-1:0]  value_r, value_nxt;
  logic [DIGITS_W-1:0] digits_r, digits_nxt;
  logic [VALUE_W-1:0]  value_upd;
  logic [DIGITS_W-1:0] digits_upd;
  logic                is_digit;
  logic [3:0]          digit;
  logic [VALUE_W+3:0]  value_x10;
  logic                dropped;
  logic                finish;

  // Divide by ten through the reciprocal 0xCCCCCCCD / 2^35, exact for any
  // value below 2^32.
  function automatic logic [VALUE_W-1:0] div10(input logic [VALUE_W-1:0] v);
    logic [VALUE_W+31:0] prod;
    prod = {32'd0, v} * {{VALUE_W{1'b0}}, 32'hCCCC_CCCD};
    return VALUE_W'(prod[VALUE_W+31:35]);
  endfunction

  assign is_digit  = (key_evt.code inside {[KEY_ZERO:KEY_NINE]});
  assign digit     = 4'(key_evt.code - KEY_ZERO);
  assign value_x10 = ({4'd0, value_r} << 3) + ({4'd0, value_r} << 1) + (VALUE_W+4)'(digit);

  always_comb begin
    value_upd  = value_r;
    digits_upd = digits_r;
    dropped    = 1'b0;
    finish     = 1'b0;
    if (key_evt.valid) begin
      if (is_digit) begin
        if (digits_r < MAX_DIGITS) begin
          value_upd  = value_x10[VALUE_W-1:0];
          digits_upd = digits_r + 4'd1;
        end else begin
          dropped = 1'b1;
        end
      end else if (key_evt.code == KEY_EQUAL) begin
        finish = 1'b1;
      end else if (key_evt.code == KEY_STAR && digits_r != 4'd0) begin
        value_upd  = div10(value_r);
        digits_upd = digits_r - 4'd1;
      end
    end
    // A finished entry is reported and then cleared.
    value_nxt  = finish ? '0 : value_upd;
    digits_nxt = finish ? '0 : digits_upd;
  end

  always_comb begin
    entry_res.number_valid  = finish;
    entry_res.number_value  = value_upd;
    entry_res.digit_count   = digits_nxt;
    entry_res.digit_dropped = dropped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r  <= '0;
      digits_r <= '0;
    end else if (advance) begin
      value_r  <= value_nxt;
      digits_r <= digits_nxt;
    end
  end

  a_digits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    digits_r <= MAX_DIGITS)
    else $error("entry holds more digits than allowed");

  // A digit is dropped only when the entry was already full.
  a_drop_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    advance && dropped |=> digits_r == MAX_DIGITS && $stable(value_r))
    else $error("digit dropped from an entry that was not full");

endmodule

`default_nettype wire

FILE: rtl/keypad_scan_number_entry_core.sv
// Top level of the 4x4 keypad scanner with decimal number entry.
// Depends on kscan_pkg, the kscan_*_if interfaces, kscan_scan and kscan_entry.
`default_nettype none

// The block is clocked by a tick stream: each input beat is one scan tick
// carrying the four column pin levels, and each accepted beat yields exactly
// one result beat with the row levels driven during that tick, the key that
// completed on it (if any) and the state of the number entry. One beat is
// accepted every clock cycle unless stalled; the result appears in the cycle
// after its input beat, held in a single output register. Because the scan and
// entry state are updated in the same cycle as the beat is accepted, a new beat
// can be taken whenever the output register is empty or is being emptied, so a
// stalled result side stalls the input side and nothing else. The scan drives
// one row low, waits settle_ticks ticks, samples the columns lowest first,
// then debounces press and release for debounce_ticks ticks each before
// reporting the key. Digits are appended to the entry (up to MAX_DIGITS, with
// digit_dropped flagging any beyond), '*' removes the last digit, '=' reports
// the number with number_valid and clears the entry, and A to D are reported
// but otherwise ignored. The two configuration registers (index 0 settle,
// index 1 debounce) are always ready and should be written only while the
// block is idle; writes to other indices are accepted and discarded.
module keypad_scan_number_entry_core (
  input wire logic   clk,
  input wire logic   rst_n,
  kscan_in_if.sink   in_ch,
  kscan_out_if.source out_ch,
  kscan_cfg_if.sink  cfg_ch
);
  import kscan_pkg::*;

  localparam logic [7:0] REG_SETTLE   = 8'd0;
  localparam logic [7:0] REG_DEBOUNCE = 8'd1;

  logic [7:0] settle_r;
  logic [7:0] debounce_r;

  logic       in_ready;
  logic       advance;
  logic [3:0] row_drive;
  key_evt_t   key_evt;
  entry_res_t entry_res;

  // Output register.
  logic            out_valid_r;
  logic [3:0]      row_drive_r;
  logic            key_valid_r;
  logic [6:0]      key_char_r;
  entry_res_t      entry_res_r;

  assign in_ready    = !out_valid_r || out_ch.ready;
  assign advance     = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r   <= 8'd10;
      debounce_r <= 8'd20;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_SETTLE) begin
        settle_r <= cfg_ch.data;
      end else if (cfg_ch.index == REG_DEBOUNCE) begin
        debounce_r <= cfg_ch.data;
      end
    end
  end

  kscan_scan u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .column_levels  (in_ch.column_levels),
    .settle_ticks   (settle_r),
    .debounce_ticks (debounce_r),
    .row_drive      (row_drive),
    .key_evt        (key_evt)
  );

  kscan_entry u_entry (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .key_evt   (key_evt),
    .entry_res (entry_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  // The payload needs no reset; it is loaded with every accepted beat.
  always_ff @(posedge clk) begin
    if (advance) begin
      row_drive_r <= row_drive;
      key_valid_r <= key_evt.valid;
      key_char_r  <= key_evt.valid ? key_evt.code : 7'd0;
      entry_res_r <= entry_res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.row_drive     = row_drive_r;
  assign out_ch.key_valid     = key_valid_r;
  assign out_ch.key_char      = key_char_r;
  assign out_ch.number_valid  = entry_res_r.number_valid;
  assign out_ch.number_value  = entry_res_r.number_value;
  assign out_ch.digit_count   = entry_res_r.digit_count;
  assign out_ch.digit_dropped = entry_res_r.digit_dropped;

  // A finished number always comes with the '=' key and an emptied entry.
  a_number_with_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && entry_res_r.number_valid |->
      key_valid_r && key_char_r == KEY_EQUAL && entry_res_r.digit_count == '0)
    else $error("number reported without '=' or entry not cleared");

  // Exactly one row is driven low on every result.
  a_one_row_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot(~row_drive_r))
    else $error("row drive does not have exactly one row low");

endmodule

`default_nettype wire

FILE: tb/sv/kscan_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the keypad scanner testbench: tick predictor, queue of
// expected result beats and field-by-field comparison. Depends on kscan_pkg.
package kscan_tb_pkg;
  import kscan_pkg::*;

  localparam logic [7:0] REG_SETTLE   = 8'd0;
  localparam logic [7:0] REG_DEBOUNCE = 8'd1;
  // Not a register: writes here must be dropped by the block.
  localparam logic [7:0] REG_SPARE    = 8'd5;
  localparam logic [6:0] KEY_LETTER_A = 7'h41;

  typedef struct packed {
    logic [3:0]          row_drive;
    logic                key_valid;
    logic [6:0]          key_char;
    logic                number_valid;
    logic [VALUE_W-1:0]  number_value;
    logic [DIGITS_W-1:0] digit_count;
    logic                digit_dropped;
  } tick_beat_t;

  class keypad_tick_board;
    string               layout = "123A456B789C*0=D";
    logic [7:0]          settle_lim;
    logic [7:0]          debounce_lim;
    scan_phase_t         phase;
    logic [1:0]          row;
    logic [1:0]          hit_col;
    logic [7:0]          count;
    logic [VALUE_W-1:0]  value;
    logic [DIGITS_W-1:0] digits;
    tick_beat_t          expected_ticks[$];
    int                  errors;

    function new();
      settle_lim   = 8'd10;
      debounce_lim = 8'd20;
      phase        = PH_SETTLE;
      row          = 2'd0;
      hit_col      = 2'd0;
      count        = 8'd0;
      value        = '0;
      digits       = '0;
      errors       = 0;
    endfunction

    function logic [6:0] key_at(input logic [1:0] r, input logic [1:0] c);
      byte ch;
      ch = layout[{r, c}];
      return ch[6:0];
    endfunction

    // Counts one tick of a wait and reports whether the wait has run out.
    function bit wait_over(input logic [7:0] lim);
      if (count < lim) begin
        count = count + 8'd1;
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void set_reg(input logic [7:0] idx, input logic [7:0] data);
      if (idx == REG_SETTLE) begin
        settle_lim = data;
      end else if (idx == REG_DEBOUNCE) begin
        debounce_lim = data;
      end
    endfunction

    function void take_tick(input logic [3:0] cols);
      tick_beat_t beat;
      logic [6:0] code;
      int         c;
      beat = '0;
      beat.row_drive = ~(4'b0001 << row);
      case (phase)
        PH_DEB_PRESS: begin
          if (wait_over(debounce_lim)) begin
            phase = PH_RELEASE;
            count = 8'd0;
          end
        end
        PH_RELEASE: begin
          if (cols[hit_col]) begin
            phase = PH_DEB_RELEASE;
            count = 8'd0;
          end
        end
        PH_DEB_RELEASE: begin
          if (wait_over(debounce_lim)) begin
            code = key_at(row, hit_col);
            beat.key_valid = 1'b1;
            beat.key_char  = code;
            if (code >= KEY_ZERO && code <= KEY_NINE) begin
              if (digits < MAX_DIGITS) begin
                value  = value * 10 + (code - KEY_ZERO);
                digits = digits + 1'b1;
              end else begin
                beat.digit_dropped = 1'b1;
              end
            end else if (code == KEY_EQUAL) begin
              beat.number_valid = 1'b1;
            end else if (code == KEY_STAR && digits != 0) begin
              value  = value / 10;
              digits = digits - 1'b1;
            end
            phase = PH_SETTLE;
            row   = 2'd0;
            count = 8'd0;
          end
        end
        default: begin
          phase = PH_SETTLE;
          if (wait_over(settle_lim)) begin
            count = 8'd0;
            if (cols != COLS_IDLE) begin
              c = 0;
              while (c < 3 && cols[c]) c++;
              hit_col = c[1:0];
              phase   = PH_DEB_PRESS;
            end else begin
              row = row + 2'd1;
            end
          end
        end
      endcase
      beat.number_value = value;
      if (beat.number_valid) begin
        value  = '0;
        digits = '0;
      end
      beat.digit_count = digits;
      expected_ticks.push_back(beat);
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] seen);
      if (want !== seen) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
        errors++;
      end
    endfunction

    function void check_tick(input tick_beat_t got);
      tick_beat_t want;
      if (expected_ticks.size() == 0) begin
        $error("result beat arrived with no tick outstanding");
        errors++;
        return;
      end
      want = expected_ticks.pop_front();
      compare_field("row_drive", want.row_drive, got.row_drive);
      compare_field("key_valid", want.key_valid, got.key_valid);
      compare_field("key_char", want.key_char, got.key_char);
      compare_field("number_valid", want.number_valid, got.number_valid);
      compare_field("number_value", want.number_value, got.number_value);
      compare_field("digit_count", want.digit_count, got.digit_count);
      compare_field("digit_dropped", want.digit_dropped, got.digit_dropped);
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction
  endclass

endpackage

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the keypad scanner testbench: clock, reset, tick driver, result
// monitor and stimulus. Depends on kscan_pkg, the kscan interfaces and kscan_tb_pkg.
module tb_top;
  import kscan_pkg::*;
  import kscan_tb_pkg::*;

  // Generous bound on the whole run. The slowest correct run is roughly one
  // thousand ticks, each waiting out a full sender gap and a full receiver
  // stall, plus the long hold-off; this is several times that.
  localparam int CYCLE_LIMIT  = 400000;
  // Ticks of randomised key traffic, not counting the directed opening and
  // the slow phase with the settle wait at its maximum.
  localparam int RANDOM_TICKS = 450;
  localparam int PHASE_TICKS  = 120;
  localparam int LONG_HOLD    = 120;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  kscan_in_if  in_ch();
  kscan_out_if out_ch();
  kscan_cfg_if cfg_ch();

  keypad_scan_number_entry_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  keypad_tick_board board = new();

  int ticks_sent = 0;
  int cycles     = 0;
  bit tx_lazy    = 1'b0;
  bit rx_lazy    = 1'b0;
  bit rx_taken   = 1'b0;
  int rx_wait    = 0;
  int rx_hold    = 0;

  // Every input of the block is at a known level from time zero.
  initial begin
    in_ch.valid         = 1'b0;
    in_ch.column_levels = COLS_IDLE;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
  end

  // Result monitor and watchdog. Everything is sampled on the rising edge,
  // before the block's own registers update, so the values seen are those of
  // the beat being handed over at this edge.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("keypad_scan_number_entry_core: mismatch");
      $finish;
    end else if (rst_n && out_ch.valid && out_ch.ready) begin
      board.check_tick(tick_beat_t'{row_drive:     out_ch.row_drive,
                                    key_valid:     out_ch.key_valid,
                                    key_char:      out_ch.key_char,
                                    number_valid:  out_ch.number_valid,
                                    number_value:  out_ch.number_value,
                                    digit_count:   out_ch.digit_count,
                                    digit_dropped: out_ch.digit_dropped});
      rx_taken = 1'b1;
    end
  end

  // Result side back-pressure. After each beat taken the receiver draws a
  // random stall while it is in its lazy mood, and none otherwise; the mood
  // flips now and then so that long runs with ready held high occur as well.
  // A long hold-off, when requested, is counted down here and takes priority
  // over the ordinary stall. Only one assignment to ready is made per falling
  // edge.
  always @(negedge clk) begin
    if (rx_taken) begin
      rx_taken = 1'b0;
      rx_wait  = rx_lazy ? $urandom_range(0, 13) : 0;
      if ($urandom_range(0, 49) == 0) rx_lazy = !rx_lazy;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_ch.ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Offers one tick beat, after an optional gap, and waits until the block
  // takes it. The predictor is advanced as soon as the beat is accepted, so
  // the stimulus can steer the next beat from the predicted scan state.
  // Entered and left at a falling edge.
  task automatic send_tick(input logic [3:0] cols);
    int gap;
    gap = tx_lazy ? $urandom_range(0, 13) : 0;
    if ($urandom_range(0, 49) == 0) tx_lazy = !tx_lazy;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.column_levels <= cols;
    do @(posedge clk); while (!in_ch.ready);
    board.take_tick(cols);
    ticks_sent++;
    @(negedge clk);
  endtask

  // Configuration beat; the channel is left low afterwards so that back-to-back
  // writes never fold into one time step.
  task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    board.set_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stops offering ticks until every predicted result beat has been seen.
  // Every tick yields a result, so once the queue is empty the block holds
  // nothing in flight and may be reconfigured.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
  endtask

  // All keys up until the scanner is back to scanning. While the block sits
  // in its release debounce the columns are ignored, so random chatter is
  // thrown in there now and then.
  task automatic let_go();
    logic [3:0] cols;
    while (board.phase != PH_SETTLE) begin
      cols = COLS_IDLE;
      if (board.phase == PH_DEB_RELEASE && $urandom_range(0, 3) == 0) cols = 4'($urandom);
      send_tick(cols);
    end
  endtask

  // One press of a physical key. The key's column reads low only while its
  // row is the one being driven, which is how a real matrix behaves. The key
  // is held until the scanner is waiting for the release, then held a little
  // longer with the odd bounce on its column, then let go. A cut-short press
  // lets go after a few ticks whatever the scanner is doing.
  task automatic strike(input logic [6:0] code, input bit cut_short);
    int         pos;
    int         cut;
    int         held;
    logic [1:0] r;
    logic [1:0] c;
    logic [3:0] cols;
    pos = 0;
    for (int i = 0; i < 16; i++) begin
      if (board.key_at(i[3:2], i[1:0]) == code) pos = i;
    end
    r    = pos[3:2];
    c    = pos[1:0];
    cut  = $urandom_range(1, 8);
    held = 0;
    while (board.phase != PH_RELEASE && !(cut_short && held >= cut)) begin
      cols = (board.row == r) ? ~(4'b0001 << c) : COLS_IDLE;
      // The press debounce ignores the columns, so noise here must not matter.
      if (board.phase == PH_DEB_PRESS && $urandom_range(0, 3) == 0) cols = 4'($urandom);
      send_tick(cols);
      held++;
    end
    repeat ($urandom_range(0, 3)) begin
      cols = (board.row == r) ? ~(4'b0001 << c) : COLS_IDLE;
      if ($urandom_range(0, 4) == 0) cols[c] = ~cols[c];
      send_tick(cols);
    end
    let_go();
    repeat ($urandom_range(0, 3)) send_tick(COLS_IDLE);
  endtask

  initial begin : stimulus
    int         phase_no;
    int         phase_start;
    int         random_start;
    int         pick;
    bit         paused;
    logic [6:0] code;

    // Synchronous reset, released once and never asserted again.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // First key under the reset settings, so that the default settle and
    // debounce counts are checked before anything is written.
    strike(KEY_ZERO + 7'd5, 1'b0);
    drain();

    // Directed keys with both waits at zero, which act on the very first
    // tick: a delete with nothing entered, a zero digit, a letter key that
    // leaves the entry alone, a delete of the one digit held and an equals
    // on an empty entry. A write to an unused index goes in as well. Then
    // one tick with every column low, where the lowest column must win.
    write_reg(REG_SETTLE, 8'd0);
    write_reg(REG_DEBOUNCE, 8'd0);
    write_reg(REG_SPARE, 8'hFF);
    strike(KEY_STAR, 1'b0);
    strike(KEY_ZERO, 1'b0);
    strike(KEY_LETTER_A + 7'd3, 1'b0);
    strike(KEY_STAR, 1'b0);
    strike(KEY_EQUAL, 1'b0);
    send_tick(4'h0);
    let_go();

    // Randomised phases, each with its own short settle and debounce counts.
    // Most traffic is well-formed key presses; some are long runs of digits
    // that fill the entry past its limit before an equals, some are presses
    // cut short, and some are bursts of arbitrary column levels.
    phase_no     = 0;
    random_start = ticks_sent;
    while (ticks_sent - random_start < RANDOM_TICKS) begin
      drain();
      write_reg(REG_SETTLE, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(4, 12))
                                                        : 8'($urandom_range(0, 3)));
      write_reg(REG_DEBOUNCE, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(4, 12))
                                                          : 8'($urandom_range(0, 3)));
      // Once, the receiver stops taking results for a long stretch while the
      // ticks keep coming, so the output register fills and input stalls.
      if (phase_no == 0) rx_hold = LONG_HOLD;
      paused      = 1'b0;
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < PHASE_TICKS) begin
        // Once, the sender stops mid-phase until every result is back.
        if (phase_no == 1 && !paused && ticks_sent - phase_start > PHASE_TICKS / 2) begin
          drain();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          code = KEY_ZERO + 7'($urandom_range(0, 9));
        end else if (pick < 86) begin
          code = KEY_EQUAL;
        end else if (pick < 93) begin
          code = KEY_STAR;
        end else begin
          code = KEY_LETTER_A + 7'($urandom_range(0, 3));
        end
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          repeat ($urandom_range(10, 12)) strike(KEY_ZERO + 7'($urandom_range(0, 9)), 1'b0);
          strike(KEY_EQUAL, 1'b0);
        end else if (pick < 20) begin
          repeat ($urandom_range(1, 6)) send_tick(4'($urandom));
        end else if (pick < 28) begin
          strike(code, 1'b1);
        end else begin
          strike(code, 1'b0);
        end
      end
      phase_no++;
    end

    // Settle wait at its maximum, with a longer debounce than elsewhere. The
    // key is taken from the row being driven right now, so the scan does not
    // have to go round all four rows at the full settle count.
    drain();
    write_reg(REG_SETTLE, 8'hFF);
    write_reg(REG_DEBOUNCE, 8'd40);
    strike(board.key_at(board.row, 2'($urandom_range(0, 3))), 1'b0);

    // Let the last results come home, then give the verdict.
    drain();
    repeat (4) @(negedge clk);
    if (board.errors == 0) begin
      $display("keypad_scan_number_entry_core: match");
    end else begin
      $display("keypad_scan_number_entry_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/kscan_pkg.sv
rtl/kscan_if.sv
rtl/kscan_scan.sv
rtl/kscan_entry.sv
rtl/keypad_scan_number_entry_core.sv
tb/sv/kscan_tb_pkg.sv
tb/sv/tb_top.sv
